/* rtl/gha_pkg.sv */
// Shared definitions for the gradient histogram accumulator: field widths,
// request and register codes, and the controller/datapath command and status structs.
// No dependencies.
package gha_pkg;

   // default storage geometry
   localparam int DEF_BINS       = 256;
   localparam int DEF_MAX_SCORES = 8;

   // request fields
   localparam int BIN_IDX_W   = 8;
   localparam int SCORE_IDX_W = 3;
   localparam int OCC_W       = 8;
   localparam int WGT_W       = 16;
   localparam int GRAD_W      = 24;
   localparam int HESS_W      = 23;

   // response fields
   localparam int CNT_SUM_W  = 32;
   localparam int WGT_SUM_W  = 40;
   localparam int GRAD_SUM_W = 60;
   localparam int HESS_SUM_W = 59;

   // products: weight Q8.8 times gradient Q4.20 or unsigned hessian Q3.20
   localparam int GRAD_PROD_W = 40;
   localparam int HESS_PROD_W = 39;

   // configuration port
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 4;
   localparam int SCORE_CNT_W   = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_MODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_COUNT = 1'd1;

   // request kinds
   localparam logic REQ_ACCUMULATE = 1'b0;
   localparam logic REQ_READ       = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic clear_step;  // zero one entry of each entry store, and of each bin store while in range
      logic latch;       // capture the accepted request
      logic mult;        // issue store reads, form products
      logic calc;        // form new sums or read-out values
      logic commit;      // write back, load response
   } gha_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;  // clearing pass at its final entry
      logic is_read;     // held request is a read-and-clear
      logic rsp_free;    // response register can take a value
   } gha_status_type;

endpackage

/* rtl/gha_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gha_ctrl.sv */
// Sequencer for the histogram accumulator: clearing pass after reset, then
// one request at a time through read, multiply, sum and write-back.
// Depends on gha_pkg.
module gha_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output gha_pkg::gha_cmd_type    cmd,
   input  gha_pkg::gha_status_type status
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MULT   = 3'd2;
   localparam logic [2:0] S_CALC   = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_MULT;
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // a read holds here until the response register frees up
            if (!status.is_read || status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

/* rtl/gha_datapath.sv */
// Datapath of the histogram accumulator: configuration, request capture,
// the four sum stores, multipliers, saturating adders and response register.
// Depends on gha_pkg and gha_ram.
module gha_datapath #(
   parameter int BINS       = gha_pkg::DEF_BINS,
   parameter int MAX_SCORES = gha_pkg::DEF_MAX_SCORES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [gha_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gha_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   req_type,
   input  logic [gha_pkg::BIN_IDX_W-1:0]          req_bin_index,
   input  logic [gha_pkg::SCORE_IDX_W-1:0]        req_score_index,
   input  logic [gha_pkg::OCC_W-1:0]              req_occurrences,
   input  logic [gha_pkg::WGT_W-1:0]              req_sample_weight,
   input  logic signed [gha_pkg::GRAD_W-1:0]      req_gradient,
   input  logic [gha_pkg::HESS_W-1:0]             req_hessian,
   input  gha_pkg::gha_cmd_type                   cmd,
   output gha_pkg::gha_status_type                status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [gha_pkg::CNT_SUM_W-1:0]          rsp_bin_count_sum,
   output logic [gha_pkg::WGT_SUM_W-1:0]          rsp_bin_weight_sum,
   output logic signed [gha_pkg::GRAD_SUM_W-1:0]  rsp_gradient_sum,
   output logic [gha_pkg::HESS_SUM_W-1:0]         rsp_hessian_sum
);

   localparam int ENTRIES = BINS * MAX_SCORES;
   localparam int BIN_AW  = $clog2(BINS);
   localparam int ENT_AW  = $clog2(ENTRIES);
   localparam int NSC_W   = ($clog2(MAX_SCORES + 1) > gha_pkg::SCORE_CNT_W) ?
                            $clog2(MAX_SCORES + 1) : gha_pkg::SCORE_CNT_W;

   localparam int CW = gha_pkg::CNT_SUM_W;
   localparam int WW = gha_pkg::WGT_SUM_W;
   localparam int GW = gha_pkg::GRAD_SUM_W;
   localparam int HW = gha_pkg::HESS_SUM_W;
   localparam int GPW = gha_pkg::GRAD_PROD_W;
   localparam int HPW = gha_pkg::HESS_PROD_W;

   // configuration
   logic                            class_mode_ff;
   logic [gha_pkg::SCORE_CNT_W-1:0] score_count_ff;

   // clearing pass
   logic [ENT_AW-1:0] sweep_ff;
   logic              sweep_bin_ok;

   // held request
   logic                              rq_type_ff;
   logic [gha_pkg::BIN_IDX_W-1:0]     rq_bin_ff;
   logic [gha_pkg::SCORE_IDX_W-1:0]   rq_sc_ff;
   logic [gha_pkg::OCC_W-1:0]         rq_occ_ff;
   logic [gha_pkg::WGT_W-1:0]         rq_wgt_ff;
   logic signed [gha_pkg::GRAD_W-1:0] rq_grad_ff;
   logic [gha_pkg::HESS_W-1:0]        rq_hess_ff;

   // products
   logic signed [GPW:0]   prod_g_full;
   logic signed [GPW-1:0] prod_g_ff;
   logic [HPW-1:0]        prod_h_in;
   logic [HPW-1:0]        prod_h_ff;

   // store read data
   logic [CW-1:0] cnt_rd;
   logic [WW-1:0] wgt_rd;
   logic [GW-1:0] grd_rd;
   logic [HW-1:0] hes_rd;

   // write-back values: new sums, or old sums on a read
   logic [CW-1:0] wb_cnt_ff, wb_cnt_in;
   logic [WW-1:0] wb_wgt_ff, wb_wgt_in;
   logic [GW-1:0] wb_grd_ff, wb_grd_in;
   logic [HW-1:0] wb_hes_ff, wb_hes_in;

   // response register
   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_cnt_ff;
   logic [WW-1:0] rsp_wgt_ff;
   logic [GW-1:0] rsp_grd_ff;
   logic [HW-1:0] rsp_hes_ff;

   // addressing and conditions
   logic [BIN_AW-1:0] bin_addr;
   logic [ENT_AW-1:0] ent_addr;
   logic [NSC_W-1:0]  nsc;
   logic              is_read, bin_ok, sc_stored, sc_used, sc_last, sc_zero;
   logic              bin_we_item, ent_we_item, hes_we_item;

   // sums
   logic [CW:0] cnt_add;
   logic [WW:0] wgt_add;
   logic [GW:0] grd_add;
   logic [HW:0] hes_add;
   logic [CW-1:0] cnt_new;
   logic [WW-1:0] wgt_new;
   logic [GW-1:0] grd_new;
   logic [HW-1:0] hes_new;

   // store ports
   logic              bin_we, ent_we, hes_we, clr_data;
   logic [BIN_AW-1:0] bin_waddr;
   logic [ENT_AW-1:0] ent_waddr;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         class_mode_ff  <= 1'b0;
         score_count_ff <= gha_pkg::SCORE_CNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gha_pkg::CSR_CLASS_MODE:  class_mode_ff  <= csr_wdata[0];
            gha_pkg::CSR_SCORE_COUNT: score_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // advance the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.clear_step) begin
         sweep_ff <= sweep_ff + ENT_AW'(1);
      end
   end

   assign sweep_bin_ok = (32'(sweep_ff) < 32'(BINS));

   // capture the accepted request
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_type_ff <= req_type;
         rq_bin_ff  <= req_bin_index;
         rq_sc_ff   <= req_score_index;
         rq_occ_ff  <= req_occurrences;
         rq_wgt_ff  <= req_sample_weight;
         rq_grad_ff <= req_gradient;
         rq_hess_ff <= req_hessian;
      end
   end

   // effective score count, clamped to 1..MAX_SCORES
   always_comb begin
      if (score_count_ff == '0) begin
         nsc = NSC_W'(1);
      end else if (NSC_W'(score_count_ff) > NSC_W'(MAX_SCORES)) begin
         nsc = NSC_W'(MAX_SCORES);
      end else begin
         nsc = NSC_W'(score_count_ff);
      end
   end

   assign bin_addr  = BIN_AW'(rq_bin_ff);
   assign ent_addr  = ENT_AW'(32'(bin_addr) * 32'(MAX_SCORES) + 32'(rq_sc_ff));
   assign is_read   = (rq_type_ff == gha_pkg::REQ_READ);
   assign bin_ok    = (32'(rq_bin_ff) < 32'(BINS));
   assign sc_stored = (32'(rq_sc_ff) < 32'(MAX_SCORES));
   assign sc_used   = (NSC_W'(rq_sc_ff) < nsc);
   assign sc_last   = (NSC_W'(rq_sc_ff) == (nsc - NSC_W'(1)));
   assign sc_zero   = (rq_sc_ff == '0);

   // which stores the held request writes: sums on accumulate, zeros on read
   assign bin_we_item = is_read ? (bin_ok && sc_last) : (bin_ok && sc_used && sc_zero);
   assign ent_we_item = is_read ? (bin_ok && sc_stored) : (bin_ok && sc_used);
   assign hes_we_item = is_read ? (bin_ok && sc_stored) :
                        (bin_ok && sc_used && class_mode_ff);

   // weighted products, registered before the adders
   assign prod_g_full = rq_grad_ff * $signed({1'b0, rq_wgt_ff});
   assign prod_h_in   = rq_hess_ff * rq_wgt_ff;

   always_ff @(posedge clock) begin
      if (cmd.mult) begin
         prod_g_ff <= prod_g_full[GPW-1:0];
         prod_h_ff <= prod_h_in;
      end
   end

   // saturating sums
   always_comb begin
      cnt_add = {1'b0, cnt_rd} + (CW + 1)'(rq_occ_ff);
      wgt_add = {1'b0, wgt_rd} + (WW + 1)'(rq_wgt_ff);
      grd_add = {grd_rd[GW-1], grd_rd} + {{(GW + 1 - GPW){prod_g_ff[GPW-1]}}, prod_g_ff};
      hes_add = {1'b0, hes_rd} + (HW + 1)'(prod_h_ff);

      cnt_new = cnt_add[CW] ? {CW{1'b1}} : cnt_add[CW-1:0];
      wgt_new = wgt_add[WW] ? {WW{1'b1}} : wgt_add[WW-1:0];
      hes_new = hes_add[HW] ? {HW{1'b1}} : hes_add[HW-1:0];
      if (grd_add[GW] != grd_add[GW-1]) begin
         // overflow: clamp toward the sign of the true sum
         grd_new = grd_add[GW] ? {1'b1, {(GW - 1){1'b0}}} : {1'b0, {(GW - 1){1'b1}}};
      end else begin
         grd_new = grd_add[GW-1:0];
      end

      if (is_read) begin
         wb_cnt_in = bin_ok ? cnt_rd : '0;
         wb_wgt_in = bin_ok ? wgt_rd : '0;
         wb_grd_in = (bin_ok && sc_stored) ? grd_rd : '0;
         wb_hes_in = (bin_ok && sc_stored) ? hes_rd : '0;
      end else begin
         wb_cnt_in = cnt_new;
         wb_wgt_in = wgt_new;
         wb_grd_in = grd_new;
         wb_hes_in = hes_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         wb_cnt_ff <= wb_cnt_in;
         wb_wgt_ff <= wb_wgt_in;
         wb_grd_ff <= wb_grd_in;
         wb_hes_ff <= wb_hes_in;
      end
   end

   // store write ports: clearing pass or write-back
   assign bin_we    = cmd.clear_step ? sweep_bin_ok : (cmd.commit && bin_we_item);
   assign ent_we    = cmd.clear_step ? 1'b1 : (cmd.commit && ent_we_item);
   assign hes_we    = cmd.clear_step ? 1'b1 : (cmd.commit && hes_we_item);
   assign bin_waddr = cmd.clear_step ? BIN_AW'(sweep_ff) : bin_addr;
   assign ent_waddr = cmd.clear_step ? sweep_ff : ent_addr;
   assign clr_data  = cmd.clear_step || is_read;

   gha_ram #(.WIDTH(CW), .DEPTH(BINS)) u_count_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (clr_data ? '0 : wb_cnt_ff),
      .rd_en   (cmd.mult),
      .rd_addr (bin_addr),
      .rd_data (cnt_rd)
   );

   gha_ram #(.WIDTH(WW), .DEPTH(BINS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (clr_data ? '0 : wb_wgt_ff),
      .rd_en   (cmd.mult),
      .rd_addr (bin_addr),
      .rd_data (wgt_rd)
   );

   gha_ram #(.WIDTH(GW), .DEPTH(ENTRIES)) u_gradient_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (clr_data ? '0 : wb_grd_ff),
      .rd_en   (cmd.mult),
      .rd_addr (ent_addr),
      .rd_data (grd_rd)
   );

   gha_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_hessian_ram (
      .clock   (clock),
      .wr_en   (hes_we),
      .wr_addr (ent_waddr),
      .wr_data (clr_data ? '0 : wb_hes_ff),
      .rd_en   (cmd.mult),
      .rd_addr (ent_addr),
      .rd_data (hes_rd)
   );

   // response register: load on a read's commit, drop on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && is_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && is_read) begin
         rsp_cnt_ff <= wb_cnt_ff;
         rsp_wgt_ff <= wb_wgt_ff;
         rsp_grd_ff <= wb_grd_ff;
         rsp_hes_ff <= wb_hes_ff;
      end
   end

   assign status.sweep_last = (sweep_ff == ENT_AW'(ENTRIES - 1));
   assign status.is_read    = is_read;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_count_sum  = rsp_cnt_ff;
   assign rsp_bin_weight_sum = rsp_wgt_ff;
   assign rsp_gradient_sum   = $signed(rsp_grd_ff);
   assign rsp_hessian_sum    = rsp_hes_ff;

endmodule

/* rtl/gradient_histogram_accumulate.sv */
// Gradient/hessian histogram accumulator for gradient boosting.
// Request channel (req_valid/req_ready): an accumulate request adds
// weight*gradient (and weight*hessian in classification mode) to the sums of
// one (bin, score) entry, and on score 0 the occurrences and weight to the
// bin's count and weight sums. A read request returns the four sums on the
// response channel (rsp_valid/rsp_ready) and clears them; the bin's count and
// weight clear only on the last score in use. All sums saturate.
// Configuration is written through csr_wr_en/csr_index/csr_wdata; the user must do so only while idle (not enforced).
// Sequence: one request at a time, through accept, store read and multiply,
// sum and write-back before the next acceptance; a read's response is valid
// the cycle after its write-back. The one-request sequence is set by the
// read-modify-write through the registered-read sum stores.
// Reset: a clearing pass zeroes every store, one entry per cycle, across all
// BINS*MAX_SCORES entries (2048 at the defaults); req_ready stays low meanwhile.
// Stall: a held response does not block the next request; a read finishing
// while the previous response is still held waits at write-back.
// Depends on gha_pkg, gha_ctrl, gha_datapath, gha_ram.
module gradient_histogram_accumulate #(
   parameter int BINS       = gha_pkg::DEF_BINS,
   parameter int MAX_SCORES = gha_pkg::DEF_MAX_SCORES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [gha_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [gha_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [gha_pkg::BIN_IDX_W-1:0]          req_bin_index,
   input  logic [gha_pkg::SCORE_IDX_W-1:0]        req_score_index,
   input  logic [gha_pkg::OCC_W-1:0]              req_occurrences,
   input  logic [gha_pkg::WGT_W-1:0]              req_sample_weight,
   input  logic signed [gha_pkg::GRAD_W-1:0]      req_gradient,
   input  logic [gha_pkg::HESS_W-1:0]             req_hessian,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [gha_pkg::CNT_SUM_W-1:0]          rsp_bin_count_sum,
   output logic [gha_pkg::WGT_SUM_W-1:0]          rsp_bin_weight_sum,
   output logic signed [gha_pkg::GRAD_SUM_W-1:0]  rsp_gradient_sum,
   output logic [gha_pkg::HESS_SUM_W-1:0]         rsp_hessian_sum
);

   gha_pkg::gha_cmd_type    cmd;
   gha_pkg::gha_status_type status;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   gha_datapath #(
      .BINS       (BINS),
      .MAX_SCORES (MAX_SCORES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_bin_index      (req_bin_index),
      .req_score_index    (req_score_index),
      .req_occurrences    (req_occurrences),
      .req_sample_weight  (req_sample_weight),
      .req_gradient       (req_gradient),
      .req_hessian        (req_hessian),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bin_count_sum  (rsp_bin_count_sum),
      .rsp_bin_weight_sum (rsp_bin_weight_sum),
      .rsp_gradient_sum   (rsp_gradient_sum),
      .rsp_hessian_sum    (rsp_hessian_sum)
   );

endmodule

/* rtl/gha_checker.sv */
// Port-level checks for the histogram accumulator, bound to its top level.
// Depends on gha_pkg and gradient_histogram_accumulate.
module gha_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [gha_pkg::CNT_SUM_W-1:0]         rsp_bin_count_sum,
   input logic [gha_pkg::WGT_SUM_W-1:0]         rsp_bin_weight_sum,
   input logic signed [gha_pkg::GRAD_SUM_W-1:0] rsp_gradient_sum,
   input logic [gha_pkg::HESS_SUM_W-1:0]        rsp_hessian_sum
);

   // the clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during the clearing pass");

   // one request in flight: no acceptance on the following cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request accepted while one is in flight");

   // a response appears only out of a write-back, never from the idle state
   a_rsp_from_writeback: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response appeared without a write-back");

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_bin_count_sum)
         && $stable(rsp_bin_weight_sum) && $stable(rsp_gradient_sum)
         && $stable(rsp_hessian_sum)))
      else $error("stalled response changed");

endmodule

bind gradient_histogram_accumulate gha_checker u_gha_checker (.*);
